/* src/umsu_pkg.sv */
// Types and constants shared by the USB-MIDI SysEx unpacker.
// No dependencies; compile first.
package umsu_pkg;

    localparam logic [7:0]  END_BYTE    = 8'hF7;
    localparam logic [16:0] LIMIT_RESET = 17'h0A000;

    localparam logic [3:0] CIN_SYSEX_START = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1  = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2  = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3  = 4'h7;

    typedef enum logic [2:0] {
        KIND_WRITE     = 3'd0,
        KIND_END       = 3'd1,
        KIND_ILLEGAL   = 3'd2,
        KIND_NOT_SYSEX = 3'd3,
        KIND_TOO_LARGE = 3'd4
    } t_kind;

    typedef struct packed {
        logic                 not_sysex;
        logic [1:0]           n_bytes;
        logic [2:0][7:0]      data;
    } t_pkt;

    typedef struct packed {
        logic valid;
        t_pkt pkt;
    } t_q_head;

endpackage

/* src/umsu_if.sv */
// Handshake channels of the SysEx unpacker: packet in, result out.
// Depends on umsu_pkg.
interface umsu_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic [7:0] data_a;
    logic [7:0] data_b;
    logic [7:0] data_c;

    modport source (output valid, header_byte, data_a, data_b, data_c, input ready);
    modport sink   (input valid, header_byte, data_a, data_b, data_c, output ready);
endinterface

interface umsu_res_if
    import umsu_pkg::*;
;
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [15:0] address;
    logic [7:0]  out_byte;
    logic        last;

    modport source (output valid, kind, address, out_byte, last, input ready);
    modport sink   (input valid, kind, address, out_byte, last, output ready);
endinterface

/* src/umsu_front.sv */
// Front end: accepts packets, decodes the code index and queues them.
// Depends on umsu_pkg and umsu_if.
module umsu_front
    import umsu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    umsu_pkt_if.sink      i_pkt,
    output t_q_head       o_head,
    input  logic          i_pop
);

    t_pkt       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    t_pkt       w_pkt;

    always_comb begin
        w_pkt.not_sysex = 1'b0;
        w_pkt.n_bytes   = 2'd3;
        w_pkt.data      = {i_pkt.data_c, i_pkt.data_b, i_pkt.data_a};
        case (i_pkt.header_byte[3:0]) inside
            CIN_SYSEX_START, CIN_SYSEX_END3: w_pkt.n_bytes = 2'd3;
            CIN_SYSEX_END2:                  w_pkt.n_bytes = 2'd2;
            CIN_SYSEX_END1:                  w_pkt.n_bytes = 2'd1;
            default:                         w_pkt.not_sysex = 1'b1;
        endcase
    end

    assign i_pkt.ready = (r_count != 2'd2);
    assign w_push      = i_pkt.valid && i_pkt.ready;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.pkt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

/* src/umsu_back.sv */
// Back end: walks the queued packet byte by byte, unpacks 7-in-8 data
// and drives the result register. Depends on umsu_pkg and umsu_if.
module umsu_back
    import umsu_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_head       i_head,
    output logic          o_pop,
    input  logic [16:0]   i_limit,
    umsu_res_if.source    o_res
);

    logic [2:0]  r_pos,    n_pos;
    logic [6:0]  r_top,    n_top;
    logic [16:0] r_wc,     n_wc;
    logic        r_halted, n_halted;
    logic [1:0]  r_idx,    n_idx;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [15:0] r_out_addr;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic                  w_step;
    logic                  w_done;
    logic                  w_emit;
    t_kind                 w_kind;
    logic [15:0]           w_addr16;
    logic [7:0]            w_byte;
    logic                  w_last;
    logic [7:0]            w_in;
    logic [7:0]            w_next;
    logic [1:0]            w_rem;
    logic [ADDR_WIDTH-1:0] w_waddr;

    assign w_step  = i_head.valid && (!r_out_valid || o_res.ready);
    assign w_in    = i_head.pkt.data[r_idx];
    assign w_next  = i_head.pkt.data[r_idx + 2'd1];
    assign w_rem   = i_head.pkt.n_bytes - 2'd1 - r_idx;
    assign w_waddr = ADDR_WIDTH'(r_wc);

    always_comb begin
        n_pos    = r_pos;
        n_top    = r_top;
        n_wc     = r_wc;
        n_halted = r_halted;
        n_idx    = r_idx;
        w_done   = 1'b0;
        w_emit   = 1'b0;
        w_kind   = KIND_WRITE;
        w_addr16 = 16'd0;
        w_byte   = 8'd0;
        w_last   = 1'b1;
        if (w_step) begin
            if (r_halted) begin
                w_done = 1'b1;
            end else if (i_head.pkt.not_sysex) begin
                w_emit   = 1'b1;
                w_kind   = KIND_NOT_SYSEX;
                n_halted = 1'b1;
                w_done   = 1'b1;
            end else if (w_in == END_BYTE) begin
                w_emit   = 1'b1;
                w_kind   = KIND_END;
                n_halted = 1'b1;
                w_done   = 1'b1;
            end else if (w_in[7]) begin
                w_emit   = 1'b1;
                w_kind   = KIND_ILLEGAL;
                n_halted = 1'b1;
                w_done   = 1'b1;
            end else if (r_pos == 3'd0) begin
                n_top = w_in[6:0];
                n_pos = 3'd1;
            end else begin
                n_pos  = (r_pos == 3'd7) ? 3'd0 : r_pos + 3'd1;
                w_emit = 1'b1;
                if (({1'b0, r_wc} + 18'd1) > {1'b0, i_limit}) begin
                    w_kind   = KIND_TOO_LARGE;
                    n_halted = 1'b1;
                    w_done   = 1'b1;
                end else begin
                    w_kind   = KIND_WRITE;
                    w_addr16 = 16'(w_waddr);
                    w_byte   = {r_top[3'd7 - r_pos], w_in[6:0]};
                    n_wc     = r_wc + 17'd1;
                    w_last   = (w_rem == 2'd0) ||
                               ((w_rem == 2'd1) && !w_next[7] && (n_pos == 3'd0));
                end
            end
            if (r_idx == i_head.pkt.n_bytes - 2'd1) begin
                w_done = 1'b1;
            end
            n_idx = w_done ? 2'd0 : r_idx + 2'd1;
        end
    end

    assign o_pop = w_step && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 3'd0;
            r_top       <= 7'd0;
            r_wc        <= 17'd0;
            r_halted    <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_top    <= n_top;
            r_wc     <= n_wc;
            r_halted <= n_halted;
            r_idx    <= n_idx;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind <= w_kind;
            r_out_addr <= w_addr16;
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.kind     = r_out_kind;
    assign o_res.address  = r_out_addr;
    assign o_res.out_byte = r_out_byte;
    assign o_res.last     = r_out_last;

endmodule

/* src/usb_midi_sysex_unpacker.sv */
// Top level of the USB-MIDI SysEx 7-in-8 unpacker: limit register,
// front end, back end. Depends on umsu_pkg, umsu_if, umsu_front, umsu_back.
//
// i_pkt carries one four-byte USB-MIDI event packet per item; o_res carries
// one result per item (byte write, end execute or an error kind), with last
// set on the final result of each packet. i_cfg_we/i_cfg_wdata load the
// byte limit; write it only while the block is idle.
// The front end decodes the code index and queues up to two packets; the
// back end handles one data byte per cycle while o_res is not stalled.
// A packet is registered in the queue, and each of its results in the
// output register; a top-bits byte yields no result of its own.
// A stalled o_res holds the back end; the queue keeps taking packets until
// it holds two. After an end or error every later packet is taken and
// dropped until reset. Synchronous reset clears the unpacker state, the
// queue and the output valid flag and loads the limit with 40960.
module usb_midi_sysex_unpacker
    import umsu_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    umsu_pkt_if.sink    i_pkt,
    umsu_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata
);

    logic [16:0] r_buffer_limit;
    t_q_head     w_head;
    logic        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_buffer_limit <= i_cfg_wdata;
        end
    end

    umsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    umsu_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_limit (r_buffer_limit),
        .o_res   (o_res)
    );

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind != KIND_WRITE) |-> o_res.last)
        else $error("error or end result without last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind != KIND_WRITE) |->
            (o_res.address == 16'd0 && o_res.out_byte == 8'd0))
        else $error("non-write result with payload");

    a_full_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pkt.ready |-> w_head.valid)
        else $error("input stalled with empty queue");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

endmodule
